/* rtl/lapef_pkg.sv */
// Shared constants, register map and stream word types for the Laplacian edge filter.
// No dependencies; included first in compile order.
`default_nettype none

package lapef_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // Laplacian sum range is -2040..2040; product with gain up to 255
  localparam int unsigned SUM_W  = 12;
  localparam int unsigned PROD_W = SUM_W + GAIN_W + 1;

  localparam int CLAMP_MAX   = 255;
  localparam int OFFSET_BASE = 128;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_MODE    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN         = 2'd3;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd480;
  localparam logic [MODE_W-1:0] RST_EDGE_MODE    = 2'd0;
  localparam logic [GAIN_W-1:0] RST_GAIN         = 8'd1;

  // edge modes
  localparam logic [MODE_W-1:0] MODE_POS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEG    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ABS    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFFSET = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             flush;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             last;
  } out_word_t;

endpackage

`default_nettype wire

/* rtl/lapef_stream_if.sv */
// Valid/ready stream channel carrying one word of a given type.
// Word types come from lapef_pkg.
`default_nettype none

interface lapef_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/laplacian_edge_filter_rgb_core.sv */
// Top level: 3x3 Laplacian edge filter on an RGB raster stream.
// Depends on lapef_pkg and lapef_stream_if.
//
// Usage:
//  - in_ch carries one pixel word per handshake (valid & ready at a rising edge).
//    A frame is frame_width*frame_height pixels followed by frame_width+1 flush
//    words (flush=1, data ignored, enters the window as black).
//  - out_ch carries one filtered word per pixel, trailing its input by one row
//    plus one pixel; the first frame_width+1 words of a frame produce nothing.
//    last marks the final pixel of the frame, after which counting restarts.
//  - cfg_* is an APB-style register port, always ready; write it only while
//    the block is idle.
// Timing: one word per cycle sustained while out_ch is ready. Pipeline is accept ->
//  line-store read / window shift -> gain, clamp and mode -> output register.
//  The line store is a single-port-write/single-read memory; a read that hits
//  the entry written in the same cycle is forwarded.
// Stall: if out_ch is held off, the two inner stages keep filling, so up to two
//  more words that produce a result are taken before in_ch.ready drops.
// Reset (rst_n low, synchronous): registers back to defaults, position counters
//  and window cleared, pipeline emptied. Line store contents are not cleared.
`default_nettype none

module laplacian_edge_filter_rgb_core #(
  parameter int unsigned MAX_WIDTH  = lapef_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lapef_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  lapef_stream_if.sink                      in_ch,
  lapef_stream_if.source                    out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lapef_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [lapef_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [lapef_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned PIX_W  = lapef_pkg::PIX_W;
  localparam int unsigned PX_W   = 3 * PIX_W;
  localparam int unsigned MEM_W  = 2 * PX_W;
  localparam int unsigned SUM_W  = lapef_pkg::SUM_W;
  localparam int unsigned PROD_W = lapef_pkg::PROD_W;
  localparam int unsigned CW     = $clog2(MAX_WIDTH);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned XW0    = (CW + 1 > RW) ? CW + 1 : RW;
  // position arithmetic width: holds dims, counters and +2 without wrap
  localparam int unsigned XW     = ((XW0 > lapef_pkg::DIM_W) ? XW0 : lapef_pkg::DIM_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [lapef_pkg::DIM_W-1:0]  frame_width_r;
  logic [lapef_pkg::DIM_W-1:0]  frame_height_r;
  logic [lapef_pkg::MODE_W-1:0] edge_mode_r;
  logic [lapef_pkg::GAIN_W-1:0] gain_r;
  logic [lapef_pkg::REG_IDX_W-1:0] cfg_idx;

  assign cfg_idx    = cfg_paddr[lapef_pkg::CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= lapef_pkg::RST_FRAME_WIDTH;
      frame_height_r <= lapef_pkg::RST_FRAME_HEIGHT;
      edge_mode_r    <= lapef_pkg::RST_EDGE_MODE;
      gain_r         <= lapef_pkg::RST_GAIN;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        lapef_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[lapef_pkg::DIM_W-1:0];
        lapef_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[lapef_pkg::DIM_W-1:0];
        lapef_pkg::REG_EDGE_MODE:    edge_mode_r    <= cfg_pwdata[lapef_pkg::MODE_W-1:0];
        lapef_pkg::REG_GAIN:         gain_r         <= cfg_pwdata[lapef_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lapef_pkg::REG_FRAME_WIDTH:  cfg_prdata = lapef_pkg::CFG_DATA_W'(frame_width_r);
      lapef_pkg::REG_FRAME_HEIGHT: cfg_prdata = lapef_pkg::CFG_DATA_W'(frame_height_r);
      lapef_pkg::REG_EDGE_MODE:    cfg_prdata = lapef_pkg::CFG_DATA_W'(edge_mode_r);
      lapef_pkg::REG_GAIN:         cfg_prdata = lapef_pkg::CFG_DATA_W'(gain_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // Effective dimensions: zero acts as one, oversize saturates at the maximum
  logic [XW-1:0] w_eff, h_eff;

  always_comb begin
    if (frame_width_r == '0)                     w_eff = XW'(1);
    else if (XW'(frame_width_r) > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else                                          w_eff = XW'(frame_width_r);
    if (frame_height_r == '0)                      h_eff = XW'(1);
    else if (XW'(frame_height_r) > XW'(MAX_HEIGHT)) h_eff = XW'(MAX_HEIGHT);
    else                                            h_eff = XW'(frame_height_r);
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_free, s2_adv, s2_free, s1_adv, in_acc;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s2_adv      = s2_v_r && out_free;
  assign s2_free     = !s2_v_r || out_free;
  assign s1_adv      = s1_v_r && s2_free;
  assign in_ch.ready = !s1_v_r || s2_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------------
  // Stage 0: raster position, output coordinates, border and end-of-frame
  // ---------------------------------------------------------------------------
  lapef_pkg::in_word_t in_word;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [XW-1:0] ic, ir, oc, orow;
  logic          restart, s0_res, s0_int, s0_last;
  logic [PX_W-1:0] s0_px;

  assign in_word = in_ch.data;
  assign s0_px   = in_word.flush ? '0 : {in_word.red_in, in_word.green_in, in_word.blue_in};

  always_comb begin
    // a row counter left out of range by a register change starts a new frame
    restart = XW'(row_r) > h_eff + XW'(1);
    ic      = restart ? '0 : XW'(col_r);
    ir      = restart ? '0 : XW'(row_r);
    s0_res  = (ir >= XW'(2)) || (ir == XW'(1) && ic != '0);
    // the pixel centered in the window: one row and one column behind
    if (ic == '0) begin
      oc   = w_eff - XW'(1);
      orow = ir - XW'(2);
    end else begin
      oc   = ic - XW'(1);
      orow = ir - XW'(1);
    end
    s0_int  = (oc >= XW'(1)) && (oc + XW'(2) <= w_eff) &&
              (orow >= XW'(1)) && (orow + XW'(2) <= h_eff);
    s0_last = s0_res && (orow == h_eff - XW'(1)) && (oc == w_eff - XW'(1));
    if (s0_last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ic + XW'(1) >= w_eff) begin
      col_nxt = '0;
      row_nxt = RW'(ir + XW'(1));
    end else begin
      col_nxt = CW'(ic + XW'(1));
      row_nxt = RW'(ir);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one entry per column holds {upper line, lower line}
  // ---------------------------------------------------------------------------
  logic [MEM_W-1:0] line_mem [MAX_WIDTH];
  logic [MEM_W-1:0] mem_q_r, fwd_data_r, s1_q, s1_wdata;
  logic             fwd_r;
  logic [CW-1:0]    rd_addr;
  logic [CW-1:0]    s1_addr_r;
  logic [PX_W-1:0]  s1_px_r, s1_top, s1_mid;
  logic             s1_res_r, s1_int_r, s1_last_r;

  assign rd_addr  = ic[CW-1:0];
  assign s1_q     = fwd_r ? fwd_data_r : mem_q_r;
  assign s1_top   = s1_q[MEM_W-1:PX_W];
  assign s1_mid   = s1_q[PX_W-1:0];
  assign s1_wdata = {s1_mid, s1_px_r};

  always_ff @(posedge clk) begin
    if (s1_adv) line_mem[s1_addr_r] <= s1_wdata;
    if (in_acc) mem_q_r <= line_mem[rd_addr];
  end

  // Same column written this cycle (one-pixel-wide frame): bypass the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_acc) begin
      fwd_r <= s1_v_r && (s1_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_data_r <= s1_wdata;
      s1_px_r    <= s0_px;
      s1_addr_r  <= rd_addr;
      s1_res_r   <= s0_res;
      s1_int_r   <= s0_int;
      s1_last_r  <= s0_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (in_acc) s1_v_r <= 1'b1;
    else if (s1_adv) s1_v_r <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: window shift and Laplacian sums
  // win_r[row][0] / [1] are the left and middle columns before the shift.
  // ---------------------------------------------------------------------------
  logic [PX_W-1:0] win_r [3][2];
  logic signed [SUM_W-1:0] lap [3];

  function automatic logic [PIX_W-1:0] chan_of(input logic [PX_W-1:0] px, input int idx);
    return px[idx*PIX_W +: PIX_W];
  endfunction

  always_comb begin
    logic [SUM_W-1:0] nb;
    for (int ch = 0; ch < 3; ch++) begin
      nb = SUM_W'(chan_of(win_r[0][0], ch)) + SUM_W'(chan_of(win_r[1][0], ch)) +
           SUM_W'(chan_of(win_r[2][0], ch)) + SUM_W'(chan_of(win_r[0][1], ch)) +
           SUM_W'(chan_of(win_r[2][1], ch)) + SUM_W'(chan_of(s1_top, ch)) +
           SUM_W'(chan_of(s1_mid, ch)) + SUM_W'(chan_of(s1_px_r, ch));
      lap[ch] = $signed(nb - (SUM_W'(chan_of(win_r[1][1], ch)) << 3));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= '0;
        win_r[k][1] <= '0;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < 3; k++) win_r[k][0] <= win_r[k][1];
      win_r[0][1] <= s1_top;
      win_r[1][1] <= s1_mid;
      win_r[2][1] <= s1_px_r;
    end
  end

  logic signed [SUM_W-1:0] s2_sum_r [3];
  logic [PX_W-1:0]         s2_cen_r;
  logic                    s2_int_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int ch = 0; ch < 3; ch++) s2_sum_r[ch] <= lap[ch];
      s2_cen_r  <= win_r[1][1];
      s2_int_r  <= s1_int_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (s1_adv) s2_v_r <= s1_res_r;
    else if (s2_adv) s2_v_r <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: gain, clamp to +-255, edge mode
  // ---------------------------------------------------------------------------
  function automatic logic [PIX_W-1:0] edge_map(
    input logic signed [SUM_W-1:0]         sum,
    input logic [lapef_pkg::GAIN_W-1:0]    g,
    input logic [lapef_pkg::MODE_W-1:0]    mode
  );
    logic signed [PROD_W-1:0] p;
    logic signed [PIX_W:0]    v;
    logic signed [PIX_W:0]    mag;
    logic [PIX_W-1:0]         res;
    p = PROD_W'(sum) * PROD_W'($signed({1'b0, g}));
    if (p > PROD_W'(lapef_pkg::CLAMP_MAX))       v = (PIX_W+1)'(lapef_pkg::CLAMP_MAX);
    else if (p < -PROD_W'(lapef_pkg::CLAMP_MAX)) v = -(PIX_W+1)'(lapef_pkg::CLAMP_MAX);
    else                                         v = p[PIX_W:0];
    mag = (v < 0) ? -v : v;
    case (mode)
      lapef_pkg::MODE_POS:    res = (v > 0) ? v[PIX_W-1:0] : '0;
      lapef_pkg::MODE_NEG:    res = (v < 0) ? mag[PIX_W-1:0] : '0;
      lapef_pkg::MODE_ABS:    res = mag[PIX_W-1:0];
      lapef_pkg::MODE_OFFSET: res = (v < 0)
          ? PIX_W'(lapef_pkg::OFFSET_BASE) - (mag[PIX_W-1:0] >> 1)
          : v[PIX_W-1:0];
      default:                res = '0;
    endcase
    return res;
  endfunction

  lapef_pkg::out_word_t out_r, out_nxt;
  logic [PIX_W-1:0] res_ch [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      // border pixels pass the window center through
      res_ch[ch] = s2_int_r ? edge_map(s2_sum_r[ch], gain_r, edge_mode_r)
                            : chan_of(s2_cen_r, ch);
    end
    out_nxt.red_out   = res_ch[2];
    out_nxt.green_out = res_ch[1];
    out_nxt.blue_out  = res_ch[0];
    out_nxt.last      = s2_last_r;
  end

  always_ff @(posedge clk) begin
    if (s2_adv) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (s2_adv) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

endmodule

`default_nettype wire
